[src/bps_pkg.sv]
// Shared constants, register codes and controller/datapath interface types.
`timescale 1ns / 1ps

package bps_pkg;

	localparam int BUCKET_DEPTH = 16;
	localparam int NUM_BUCKETS  = 4;
	localparam int BKT_W        = 2;
	localparam int FILL_W       = $clog2(BUCKET_DEPTH + 1);
	localparam int IDX_W        = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
	localparam int ADDR_W       = BKT_W + IDX_W;
	localparam int MEM_DEPTH    = 1 << ADDR_W;
	localparam int VAL_W        = 16;
	localparam int BOUND_W      = 15;
	localparam int DROP_W       = 8;
	localparam int CFG_IDX_W    = 2;

	localparam logic [CFG_IDX_W-1:0] REG_BOUND_ONE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOUND_TWO   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOUND_THREE = 2'd2;

	localparam logic [BOUND_W-1:0] BOUND_ONE_RST   = 15'd10;
	localparam logic [BOUND_W-1:0] BOUND_TWO_RST   = 15'd20;
	localparam logic [BOUND_W-1:0] BOUND_THREE_RST = 15'd30;

	localparam logic [BKT_W-1:0] LAST_BUCKET = BKT_W'(NUM_BUCKETS - 1);

	typedef struct packed {
		logic load;        // capture an incoming item
		logic file;        // classify, check fill, start the insert
		logic shift;       // move one larger entry up a place
		logic place;       // write the new value and bump the fill
		logic emit_start;  // rewind to bucket 0, entry 0
		logic next_bucket; // step to the next bucket
		logic emit_rd;     // read the current entry for output
		logic emit_ld;     // load the output register
		logic clear;       // empty all buckets and the drop count
	} cmd_t;

	typedef struct packed {
		logic full;        // classified bucket is full
		logic shift_go;    // entry below the hole is larger than the value
		logic final_item;  // held item is the last of the set
		logic have_entry;  // emit position lies below the bucket fill
		logic last_bucket; // emitting from the last bucket
		logic out_free;    // output register is empty or being taken
	} sts_t;

endpackage

[src/bps_ctrl.sv]
// Sequencer for filing, insertion shifting and emission of the buckets.
`timescale 1ns / 1ps

module bps_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          sample_valid,
	output logic          sample_stall,
	input  bps_pkg::sts_t sts,
	output bps_pkg::cmd_t cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FILE  = 3'd1;
	localparam logic [2:0] S_SHIFT = 3'd2;
	localparam logic [2:0] S_E_RD  = 3'd3;
	localparam logic [2:0] S_E_LD  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign sample_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (sample_valid) begin
					cmd.load = 1'b1;
					state_d  = S_FILE;
				end
			end
			S_FILE: begin
				cmd.file = 1'b1;
				if (sts.full) begin
					if (sts.final_item) begin
						cmd.emit_start = 1'b1;
						state_d        = S_E_RD;
					end else begin
						state_d = S_IDLE;
					end
				end else begin
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				if (sts.shift_go) begin
					cmd.shift = 1'b1;
				end else begin
					cmd.place = 1'b1;
					if (sts.final_item) begin
						cmd.emit_start = 1'b1;
						state_d        = S_E_RD;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_E_RD: begin
				if (!sts.have_entry) begin
					if (sts.last_bucket) begin
						cmd.clear = 1'b1;
						state_d   = S_IDLE;
					end else begin
						cmd.next_bucket = 1'b1;
					end
				end else if (sts.out_free) begin
					cmd.emit_rd = 1'b1;
					state_d     = S_E_LD;
				end
			end
			S_E_LD: begin
				cmd.emit_ld = 1'b1;
				state_d     = S_E_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[src/bps_datapath.sv]
// Bucket memory, fill and drop counters, bound registers and result register.
`timescale 1ns / 1ps

module bps_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bps_pkg::cmd_t                     cmd,
	output bps_pkg::sts_t                     sts,
	input  logic signed [bps_pkg::VAL_W-1:0]  sample_value,
	input  logic                              final_sample,
	input  logic                              cfg_valid,
	input  logic [bps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bps_pkg::BOUND_W-1:0]       cfg_data,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic signed [bps_pkg::VAL_W-1:0]  sorted_value,
	output logic [bps_pkg::BKT_W-1:0]         bucket_index,
	output logic                              bucket_end,
	output logic                              run_end,
	output logic [bps_pkg::DROP_W-1:0]        dropped_total
);

	logic [bps_pkg::BOUND_W-1:0] bound_one_q;
	logic [bps_pkg::BOUND_W-1:0] bound_two_q;
	logic [bps_pkg::BOUND_W-1:0] bound_three_q;

	logic [bps_pkg::VAL_W-1:0]   mem_q [bps_pkg::MEM_DEPTH];
	logic [bps_pkg::VAL_W-1:0]   rd_q;

	logic [bps_pkg::FILL_W-1:0]  fill_q [bps_pkg::NUM_BUCKETS];
	logic [bps_pkg::DROP_W-1:0]  drop_q;

	logic signed [bps_pkg::VAL_W-1:0] v_q;
	logic                         final_q;
	logic [bps_pkg::BKT_W-1:0]    bkt_q;
	logic [bps_pkg::FILL_W-1:0]   pos_q;

	logic [bps_pkg::BKT_W-1:0]    bkt_s1;
	logic                         bend_s1;
	logic                         rend_s1;

	logic                         res_valid_q;
	logic [bps_pkg::VAL_W-1:0]    res_value_q;
	logic [bps_pkg::BKT_W-1:0]    res_bkt_q;
	logic                         res_bend_q;
	logic                         res_rend_q;
	logic [bps_pkg::DROP_W-1:0]   res_drop_q;

	logic signed [bps_pkg::VAL_W:0] v_ext;
	logic signed [bps_pkg::VAL_W:0] b1_ext;
	logic signed [bps_pkg::VAL_W:0] b2_ext;
	logic signed [bps_pkg::VAL_W:0] b3_ext;
	logic [bps_pkg::BKT_W-1:0]      cls;
	logic [bps_pkg::FILL_W-1:0]     cls_fill;
	logic [bps_pkg::FILL_W-1:0]     cur_fill;
	logic [bps_pkg::FILL_W-1:0]     pos_dec;
	logic [bps_pkg::FILL_W-1:0]     pos_dec2;
	logic [bps_pkg::FILL_W-1:0]     pos_inc;
	logic [bps_pkg::FILL_W-1:0]     cls_dec;
	logic                           later_empty;

	logic                         rd_en;
	logic [bps_pkg::ADDR_W-1:0]   rd_addr;
	logic                         wr_en;
	logic [bps_pkg::ADDR_W-1:0]   wr_addr;
	logic [bps_pkg::VAL_W-1:0]    wr_data;

	// Bounds are unsigned, so they widen with zeros; the sample widens by sign.
	assign v_ext  = {v_q[bps_pkg::VAL_W-1], v_q};
	assign b1_ext = $signed({2'b00, bound_one_q});
	assign b2_ext = $signed({2'b00, bound_two_q});
	assign b3_ext = $signed({2'b00, bound_three_q});

	always_comb begin
		if (v_ext >= 0 && v_ext < b1_ext) begin
			cls = 2'd0;
		end else if (v_ext >= b1_ext && v_ext < b2_ext) begin
			cls = 2'd1;
		end else if (v_ext >= b2_ext && v_ext < b3_ext) begin
			cls = 2'd2;
		end else begin
			cls = bps_pkg::LAST_BUCKET;
		end
	end

	assign cls_fill = fill_q[cls];
	assign cur_fill = fill_q[bkt_q];
	assign cls_dec  = cls_fill - bps_pkg::FILL_W'(1);
	assign pos_dec  = pos_q - bps_pkg::FILL_W'(1);
	assign pos_dec2 = pos_q - bps_pkg::FILL_W'(2);
	assign pos_inc  = pos_q + bps_pkg::FILL_W'(1);

	// The run ends on the last entry of the last bucket that holds anything.
	always_comb begin
		later_empty = 1'b1;
		for (int b = 0; b < bps_pkg::NUM_BUCKETS; b++) begin
			if (bps_pkg::BKT_W'(b) > bkt_q && fill_q[b] != '0) begin
				later_empty = 1'b0;
			end
		end
	end

	always_comb begin
		sts.full        = (cls_fill == bps_pkg::FILL_W'(bps_pkg::BUCKET_DEPTH));
		sts.shift_go    = (pos_q != '0) && ($signed(rd_q) > v_q);
		sts.final_item  = final_q;
		sts.have_entry  = (pos_q < cur_fill);
		sts.last_bucket = (bkt_q == bps_pkg::LAST_BUCKET);
		sts.out_free    = !res_valid_q || !result_stall;
	end

	// While shifting, the read one place below the next hole is already in flight.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = {cls, cls_dec[bps_pkg::IDX_W-1:0]};
		if (cmd.file) begin
			rd_en   = 1'b1;
			rd_addr = {cls, cls_dec[bps_pkg::IDX_W-1:0]};
		end else if (cmd.shift) begin
			rd_en   = 1'b1;
			rd_addr = {bkt_q, pos_dec2[bps_pkg::IDX_W-1:0]};
		end else if (cmd.emit_rd) begin
			rd_en   = 1'b1;
			rd_addr = {bkt_q, pos_q[bps_pkg::IDX_W-1:0]};
		end
	end

	assign wr_en   = cmd.shift || cmd.place;
	assign wr_addr = {bkt_q, pos_q[bps_pkg::IDX_W-1:0]};
	assign wr_data = cmd.shift ? rd_q : v_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_one_q   <= bps_pkg::BOUND_ONE_RST;
			bound_two_q   <= bps_pkg::BOUND_TWO_RST;
			bound_three_q <= bps_pkg::BOUND_THREE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bps_pkg::REG_BOUND_ONE:   bound_one_q   <= cfg_data;
				bps_pkg::REG_BOUND_TWO:   bound_two_q   <= cfg_data;
				bps_pkg::REG_BOUND_THREE: bound_three_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < bps_pkg::NUM_BUCKETS; b++) begin
				fill_q[b] <= '0;
			end
			drop_q <= '0;
		end else if (cmd.clear) begin
			for (int b = 0; b < bps_pkg::NUM_BUCKETS; b++) begin
				fill_q[b] <= '0;
			end
			drop_q <= '0;
		end else begin
			if (cmd.place) begin
				fill_q[bkt_q] <= cur_fill + bps_pkg::FILL_W'(1);
			end
			if (cmd.file && sts.full && drop_q != '1) begin
				drop_q <= drop_q + bps_pkg::DROP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_q     <= sample_value;
			final_q <= final_sample;
		end
		if (cmd.emit_start) begin
			bkt_q <= '0;
			pos_q <= '0;
		end else if (cmd.file) begin
			bkt_q <= cls;
			pos_q <= cls_fill;
		end else if (cmd.shift) begin
			pos_q <= pos_dec;
		end else if (cmd.next_bucket) begin
			bkt_q <= bkt_q + bps_pkg::BKT_W'(1);
			pos_q <= '0;
		end else if (cmd.emit_ld) begin
			pos_q <= pos_inc;
		end
		if (cmd.emit_rd) begin
			bkt_s1  <= bkt_q;
			bend_s1 <= (pos_inc == cur_fill);
			rend_s1 <= (pos_inc == cur_fill) && later_empty;
		end
		if (cmd.emit_ld) begin
			res_value_q <= rd_q;
			res_bkt_q   <= bkt_s1;
			res_bend_q  <= bend_s1;
			res_rend_q  <= rend_s1;
			res_drop_q  <= drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit_ld) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign result_valid  = res_valid_q;
	assign sorted_value  = $signed(res_value_q);
	assign bucket_index  = res_bkt_q;
	assign bucket_end    = res_bend_q;
	assign run_end       = res_rend_q;
	assign dropped_total = res_drop_q;

endmodule

[src/bucket_partition_sorter_core.sv]
// Top level of the bucket partition sorter: controller plus datapath.
`timescale 1ns / 1ps

// Samples arrive one item at a time and are filed into four buckets split by the
// three bound registers; each bucket is kept ascending by insertion in a single
// memory with one write and one registered read port. A sample is loaded, filed
// and placed after k (0 to 15) larger entries have been shifted up one place,
// one per cycle through the memory's read and write ports; a sample that
// meets a full bucket is counted as dropped. The item
// marked final_sample then starts the emission run: every stored value comes
// out by a memory read and then the output register while the output is
// free, each bucket takes one more step past its end, and the input stays
// stalled until the run has been queued, after which all buckets and the drop
// count are cleared. The last result may still wait in the output register
// while the next sample is accepted. Bounds are to be written by the user
// through the cfg port only while the block is idle, which is not enforced.
module bucket_partition_sorter_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	output logic                              sample_stall,
	input  logic signed [bps_pkg::VAL_W-1:0]  sample_value,
	input  logic                              final_sample,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bps_pkg::BOUND_W-1:0]       cfg_data,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic signed [bps_pkg::VAL_W-1:0]  sorted_value,
	output logic [bps_pkg::BKT_W-1:0]         bucket_index,
	output logic                              bucket_end,
	output logic                              run_end,
	output logic [bps_pkg::DROP_W-1:0]        dropped_total
);

	bps_pkg::cmd_t cmd;
	bps_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	bps_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	bps_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.sample_value  (sample_value),
		.final_sample  (final_sample),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.sorted_value  (sorted_value),
		.bucket_index  (bucket_index),
		.bucket_end    (bucket_end),
		.run_end       (run_end),
		.dropped_total (dropped_total)
	);

endmodule

[tb/tb_bucket_partition_sorter_core.sv]
// Self-checking testbench for the bucket partition sorter core.
`timescale 1ns / 1ps

module tb_bucket_partition_sorter_core;

	localparam logic [bps_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int SETTLE_CYCLES = 40;
	localparam int LONG_HOLD     = 300;
	localparam int RANDOM_ITEMS  = 160;
	localparam int PRESSURE_SET  = 3;
	localparam int OVERFLOW_FILL = bps_pkg::BUCKET_DEPTH + 8;
	localparam int MAX_DROPS     = 255;

	typedef struct packed {
		logic signed [bps_pkg::VAL_W-1:0] value;
		logic [bps_pkg::BKT_W-1:0]        bucket;
		logic                             bkt_end;
		logic                             last;
		logic [bps_pkg::DROP_W-1:0]       drops;
	} result_t;

	typedef enum logic [0:0] {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t                        kind;
		logic [bps_pkg::CFG_IDX_W-1:0]    reg_idx;
		logic [bps_pkg::BOUND_W-1:0]      reg_data;
		logic signed [bps_pkg::VAL_W-1:0] value;
		logic                             fin;
		logic [8:0]                       reps;
		logic                             typed;
		result_t                          want;
	} row_t;

	logic                             clk;
	logic                             arst_n;
	logic                             sample_valid;
	logic                             sample_stall;
	logic signed [bps_pkg::VAL_W-1:0] sample_value;
	logic                             final_sample;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [bps_pkg::CFG_IDX_W-1:0]    cfg_index;
	logic [bps_pkg::BOUND_W-1:0]      cfg_data;
	logic                             result_valid;
	logic                             result_stall;
	logic signed [bps_pkg::VAL_W-1:0] sorted_value;
	logic [bps_pkg::BKT_W-1:0]        bucket_index;
	logic                             bucket_end;
	logic                             run_end;
	logic [bps_pkg::DROP_W-1:0]       dropped_total;

	// Predictor state: the bounds, the ordered bucket contents and the drop count.
	logic [bps_pkg::BOUND_W-1:0]      lim_one;
	logic [bps_pkg::BOUND_W-1:0]      lim_two;
	logic [bps_pkg::BOUND_W-1:0]      lim_three;
	logic signed [bps_pkg::VAL_W-1:0] held_vals [bps_pkg::NUM_BUCKETS][bps_pkg::BUCKET_DEPTH];
	int                               held_cnt [bps_pkg::NUM_BUCKETS];
	int                               drop_cnt;

	result_t                          sorted_due[$];
	row_t                             dir_rows[$];
	result_t                          seen_res;
	result_t                          due_res;
	logic                             row_typed;
	result_t                          row_want;

	int                               mismatches;
	int                               results_checked;
	int                               samples_taken;
	int                               runs_seen;
	int                               peak_drops;
	int                               bound_writes;
	int                               hold_asked;
	int                               hold_served;

	bucket_partition_sorter_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.sample_value  (sample_value),
		.final_sample  (final_sample),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.sorted_value  (sorted_value),
		.bucket_index  (bucket_index),
		.bucket_end    (bucket_end),
		.run_end       (run_end),
		.dropped_total (dropped_total)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Files one sample into its bucket; a final sample also queues the whole run.
	task automatic bucket_sort_sample(input logic signed [bps_pkg::VAL_W-1:0] v,
			input logic fin, input logic typed, input result_t want);
		int sv, b1, b2, b3, bkt, n, total, k;
		result_t r;
		sv = v;
		b1 = lim_one;
		b2 = lim_two;
		b3 = lim_three;
		if (sv >= 0 && sv < b1)
			bkt = 0;
		else if (sv >= b1 && sv < b2)
			bkt = 1;
		else if (sv >= b2 && sv < b3)
			bkt = 2;
		else
			bkt = 3;
		n = held_cnt[bkt];
		if (n >= bps_pkg::BUCKET_DEPTH) begin
			if (drop_cnt < MAX_DROPS)
				drop_cnt++;
		end else begin
			while (n > 0 && held_vals[bkt][n-1] > v) begin
				held_vals[bkt][n] = held_vals[bkt][n-1];
				n--;
			end
			held_vals[bkt][n] = v;
			held_cnt[bkt]++;
		end
		if (fin) begin
			if (typed) begin
				sorted_due.push_back(want);
			end else begin
				total = 0;
				for (int b = 0; b < bps_pkg::NUM_BUCKETS; b++)
					total += held_cnt[b];
				k = 0;
				for (int b = 0; b < bps_pkg::NUM_BUCKETS; b++) begin
					for (int i = 0; i < held_cnt[b]; i++) begin
						r.value   = held_vals[b][i];
						r.bucket  = bps_pkg::BKT_W'(b);
						r.bkt_end = (i == held_cnt[b] - 1);
						r.last    = (k == total - 1);
						r.drops   = bps_pkg::DROP_W'(drop_cnt);
						sorted_due.push_back(r);
						k++;
					end
				end
			end
			if (drop_cnt > peak_drops)
				peak_drops = drop_cnt;
			for (int b = 0; b < bps_pkg::NUM_BUCKETS; b++)
				held_cnt[b] = 0;
			drop_cnt = 0;
			runs_seen++;
		end
	endtask

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%s: expected value %0d bucket %0d end %0d run_end %0d drops %0d,",
				what, due_res.value, due_res.bucket, due_res.bkt_end, due_res.last,
				due_res.drops);
			$display("    got value %0d bucket %0d end %0d run_end %0d drops %0d",
				seen_res.value, seen_res.bucket, seen_res.bkt_end, seen_res.last,
				seen_res.drops);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				seen_res.value   = sorted_value;
				seen_res.bucket  = bucket_index;
				seen_res.bkt_end = bucket_end;
				seen_res.last    = run_end;
				seen_res.drops   = dropped_total;
				results_checked++;
				if (sorted_due.size() == 0) begin
					due_res = '0;
					report_mismatch("unexpected result");
				end else begin
					due_res = sorted_due.pop_front();
					if (seen_res.value !== due_res.value ||
							seen_res.bucket !== due_res.bucket ||
							seen_res.bkt_end !== due_res.bkt_end ||
							seen_res.last !== due_res.last ||
							seen_res.drops !== due_res.drops)
						report_mismatch("result mismatch");
				end
			end
			if (sample_valid && !sample_stall) begin
				bucket_sort_sample(sample_value, final_sample, row_typed, row_want);
				samples_taken++;
			end
		end
	end

	// Result side: random stalls, free-running stretches and one long hold-off on request.
	initial begin
		int stall_left;
		int free_left;
		stall_left = 0;
		free_left = 0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_asked != hold_served) begin
				hold_served++;
				result_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				result_stall <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
				if (free_left > 0) begin
					free_left--;
				end else begin
					stall_left = gap_len();
					free_left = ($urandom_range(0, 19) == 0) ? 150 : $urandom_range(0, 5);
				end
			end
		end
	end

	task automatic offer_sample(input logic signed [bps_pkg::VAL_W-1:0] v, input logic fin,
			input int gap, input logic typed, input result_t want);
		if (gap > 0) begin
			@(negedge clk);
			sample_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		sample_valid <= 1'b1;
		sample_value <= v;
		final_sample <= fin;
		row_typed = typed;
		row_want = want;
		do @(posedge clk); while (sample_stall);
	endtask

	// Waits until every queued result has come out and the core has settled.
	task automatic wait_idle();
		@(negedge clk);
		while (sorted_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_bound(input logic [bps_pkg::CFG_IDX_W-1:0] idx,
			input logic [bps_pkg::BOUND_W-1:0] data);
		// The last sample is withdrawn before the core can take it a second time.
		@(negedge clk);
		sample_valid <= 1'b0;
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			bps_pkg::REG_BOUND_ONE:   lim_one = data;
			bps_pkg::REG_BOUND_TWO:   lim_two = data;
			bps_pkg::REG_BOUND_THREE: lim_three = data;
			default: ;
		endcase
		bound_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [bps_pkg::VAL_W-1:0] pick_value();
		int t;
		case ($urandom_range(0, 9))
			0, 1, 2: t = $urandom;
			3, 4, 5: begin
				case ($urandom_range(0, 3))
					0: t = lim_one;
					1: t = lim_two;
					2: t = lim_three;
					default: t = 0;
				endcase
				t = t + $urandom_range(0, 4) - 2;
			end
			6, 7, 8: t = $urandom_range(0, (lim_three > 32000) ? 32767 : lim_three + 4);
			default: begin
				case ($urandom_range(0, 3))
					0: t = 32767;
					1: t = -32768;
					2: t = 0;
					default: t = -1;
				endcase
			end
		endcase
		return t[bps_pkg::VAL_W-1:0];
	endfunction

	function automatic void add_sample(input int v, input logic fin, input int reps,
			input logic typed, input result_t want);
		row_t r;
		r = '0;
		r.kind = ROW_SAMPLE;
		r.value = v[bps_pkg::VAL_W-1:0];
		r.fin = fin;
		r.reps = reps[8:0];
		r.typed = typed;
		r.want = want;
		dir_rows.push_back(r);
	endfunction

	function automatic void add_write(input logic [bps_pkg::CFG_IDX_W-1:0] idx,
			input int data);
		row_t r;
		r = '0;
		r.kind = ROW_WRITE;
		r.reg_idx = idx;
		r.reg_data = data[bps_pkg::BOUND_W-1:0];
		dir_rows.push_back(r);
	endfunction

	initial begin
		row_t row;
		int rand_items;
		int set_no;
		int len;
		int t;
		int waited;
		logic [bps_pkg::BOUND_W-1:0] nb1, nb2, nb3;
		bit smooth;

		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample_value = '0;
		final_sample = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = bps_pkg::REG_BOUND_ONE;
		cfg_data = '0;
		row_typed = 1'b0;
		row_want = '0;
		lim_one = bps_pkg::BOUND_ONE_RST;
		lim_two = bps_pkg::BOUND_TWO_RST;
		lim_three = bps_pkg::BOUND_THREE_RST;
		for (int b = 0; b < bps_pkg::NUM_BUCKETS; b++)
			held_cnt[b] = 0;
		drop_cnt = 0;
		mismatches = 0;
		results_checked = 0;
		samples_taken = 0;
		runs_seen = 0;
		peak_drops = 0;
		bound_writes = 0;
		hold_asked = 0;
		hold_served = 0;

		// Reset bounds: a lone value, then every bucket edge and the value extremes.
		add_sample(5, 1'b1, 1, 1'b1, result_t'{16'sd5, 2'd0, 1'b1, 1'b1, 8'd0});
		add_sample(32767, 1'b0, 1, 1'b0, '0);
		add_sample(-32768, 1'b0, 1, 1'b0, '0);
		add_sample(0, 1'b0, 1, 1'b0, '0);
		add_sample(-1, 1'b0, 1, 1'b0, '0);
		add_sample(10, 1'b0, 2, 1'b0, '0);
		add_sample(20, 1'b0, 1, 1'b0, '0);
		add_sample(30, 1'b0, 1, 1'b0, '0);
		add_sample(29, 1'b1, 1, 1'b0, '0);
		// Fill bucket 0, then drop the final item on the full bucket.
		add_sample(3, 1'b0, bps_pkg::BUCKET_DEPTH, 1'b0, '0);
		add_sample(4, 1'b1, 1, 1'b0, '0);
		// All bounds at zero put everything in the last bucket.
		add_write(bps_pkg::REG_BOUND_ONE, 0);
		add_write(bps_pkg::REG_BOUND_TWO, 0);
		add_write(bps_pkg::REG_BOUND_THREE, 0);
		add_sample(0, 1'b1, 1, 1'b1, result_t'{16'sd0, 2'd3, 1'b1, 1'b1, 8'd0});
		// All bounds at the top; a write to the unused index changes nothing.
		add_write(bps_pkg::REG_BOUND_ONE, 32767);
		add_write(bps_pkg::REG_BOUND_TWO, 32767);
		add_write(bps_pkg::REG_BOUND_THREE, 32767);
		add_write(REG_SPARE, 15'h5555);
		add_sample(32767, 1'b1, 1, 1'b1, result_t'{16'sd32767, 2'd3, 1'b1, 1'b1, 8'd0});
		// Bounds out of order are used as given.
		add_write(bps_pkg::REG_BOUND_ONE, 5);
		add_write(bps_pkg::REG_BOUND_TWO, 30);
		add_write(bps_pkg::REG_BOUND_THREE, 20);
		add_sample(25, 1'b0, 1, 1'b0, '0);
		add_sample(40, 1'b0, 1, 1'b0, '0);
		add_sample(3, 1'b1, 1, 1'b0, '0);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.kind == ROW_WRITE) begin
				write_bound(row.reg_idx, row.reg_data);
			end else begin
				for (int r = 0; r < row.reps; r++)
					offer_sample(row.value, row.fin, gap_len(), row.typed, row.want);
			end
		end

		rand_items = 0;
		set_no = 0;
		while (rand_items < RANDOM_ITEMS) begin
			set_no++;
			if (set_no % 4 == 1 || $urandom_range(0, 5) == 0) begin
				case ($urandom_range(0, 3))
					0: begin
						nb1 = bps_pkg::BOUND_W'($urandom_range(0, 40));
						nb2 = bps_pkg::BOUND_W'(nb1 + $urandom_range(0, 20));
						nb3 = bps_pkg::BOUND_W'(nb2 + $urandom_range(0, 20));
					end
					1: begin
						nb1 = bps_pkg::BOUND_W'($urandom_range(0, 10000));
						nb2 = bps_pkg::BOUND_W'(nb1 + $urandom_range(0, 10000));
						nb3 = bps_pkg::BOUND_W'(nb2 + $urandom_range(0, 12000));
					end
					2: begin
						nb1 = bps_pkg::BOUND_W'($urandom);
						nb2 = bps_pkg::BOUND_W'($urandom);
						nb3 = bps_pkg::BOUND_W'($urandom);
					end
					default: begin
						nb1 = lim_one;
						nb2 = lim_two;
						nb3 = lim_three;
						case ($urandom_range(0, 2))
							0: nb1 = bps_pkg::BOUND_W'($urandom);
							1: nb2 = bps_pkg::BOUND_W'($urandom);
							default: nb3 = bps_pkg::BOUND_W'($urandom);
						endcase
					end
				endcase
				if (nb1 != lim_one)
					write_bound(bps_pkg::REG_BOUND_ONE, nb1);
				if (nb2 != lim_two)
					write_bound(bps_pkg::REG_BOUND_TWO, nb2);
				if (nb3 != lim_three)
					write_bound(bps_pkg::REG_BOUND_THREE, nb3);
			end
			len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 24) : $urandom_range(25, 45);
			smooth = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < len; k++) begin
				// Hold the result side off as the run starts, while more items keep coming.
				if (set_no == PRESSURE_SET && k == len - 1)
					hold_asked++;
				offer_sample(pick_value(), k == len - 1, smooth ? 0 : gap_len(), 1'b0, '0);
				rand_items++;
			end
		end

		// One set of negatives overfills the last bucket, so its later items are dropped.
		for (int k = 0; k < OVERFLOW_FILL; k++) begin
			t = -int'($urandom_range(1, 32768));
			offer_sample(t[bps_pkg::VAL_W-1:0], k == OVERFLOW_FILL - 1,
				($urandom_range(0, 9) == 0) ? gap_len() : 0, 1'b0, '0);
		end

		@(negedge clk);
		sample_valid <= 1'b0;
		waited = 0;
		while (sorted_due.size() != 0 && waited < 50000) begin
			@(negedge clk);
			waited++;
		end
		if (sorted_due.size() != 0) begin
			$display("%0d expected results never arrived", sorted_due.size());
			mismatches += sorted_due.size();
		end
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Checked %0d sorted results from %0d samples over %0d data sets.",
			results_checked, samples_taken, runs_seen);
		$display("Bound writes: %0d, highest drop count: %0d, mismatches: %0d.",
			bound_writes, peak_drops, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
